>>> hdl/ihsp_pkg.sv
package ihsp_pkg;

    // format codes of a result
    localparam logic [1:0] FMT_UNKNOWN = 2'd0;
    localparam logic [1:0] FMT_PNG     = 2'd1;
    localparam logic [1:0] FMT_GIF     = 2'd2;
    localparam logic [1:0] FMT_JPEG    = 2'd3;

    // signature and marker bytes
    localparam logic [7:0] BYTE_PNG0  = 8'h89;
    localparam logic [7:0] BYTE_GIF_G = 8'h47;
    localparam logic [7:0] BYTE_GIF_I = 8'h49;
    localparam logic [7:0] BYTE_GIF_F = 8'h46;
    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] MARK_SOI   = 8'hD8;
    localparam logic [7:0] MARK_TEM   = 8'h01;
    localparam logic [7:0] MARK_RST0  = 8'hD0;
    localparam logic [7:0] MARK_RST7  = 8'hD7;
    localparam logic [7:0] MARK_SOF0  = 8'hC0;
    localparam logic [7:0] MARK_SOF15 = 8'hCF;
    localparam logic [7:0] MARK_DHT   = 8'hC4;
    localparam logic [7:0] MARK_JPG   = 8'hC8;
    localparam logic [7:0] MARK_DAC   = 8'hCC;

    // parser phases
    typedef enum logic [10:0] {
        PH_FIRST = 11'b000_0000_0001,
        PH_PNG   = 11'b000_0000_0010,
        PH_GIF   = 11'b000_0000_0100,
        PH_SOI   = 11'b000_0000_1000,
        PH_MARK0 = 11'b000_0001_0000,
        PH_MARK1 = 11'b000_0010_0000,
        PH_LEN0  = 11'b000_0100_0000,
        PH_LEN1  = 11'b000_1000_0000,
        PH_SKIP  = 11'b001_0000_0000,
        PH_SOF   = 11'b010_0000_0000,
        PH_DONE  = 11'b100_0000_0000
    } t_phase;

    // complete parser state
    typedef struct packed {
        logic [4:0]  byte_offset;
        t_phase      phase;
        logic [15:0] skip_count;
        logic [7:0]  current_marker;
        logic [7:0]  length_high;
        logic [2:0]  sof_index;
        logic [31:0] width_acc;
        logic [31:0] height_acc;
        logic [1:0]  format_seen;
        logic        found_flag;
    } t_parse_state;

    // one finished result
    typedef struct packed {
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [1:0]  image_format;
        logic        dims_found;
    } t_result;

    localparam t_parse_state STATE_RESET = '{
        byte_offset:    5'd0,
        phase:          PH_FIRST,
        skip_count:     16'd0,
        current_marker: 8'd0,
        length_high:    8'd0,
        sof_index:      3'd0,
        width_acc:      32'd0,
        height_acc:     32'd0,
        format_seen:    FMT_UNKNOWN,
        found_flag:     1'b0
    };

    // expected png signature byte at a given offset
    function automatic logic [7:0] png_sig(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h89;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h4E;
            3'd3:    v = 8'h47;
            3'd4:    v = 8'h0D;
            3'd5:    v = 8'h0A;
            3'd6:    v = 8'h1A;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

    // markers that carry no length
    function automatic logic is_standalone(input logic [7:0] m);
        return (m == MARK_SOI) || (m == MARK_TEM) || ((m >= MARK_RST0) && (m <= MARK_RST7));
    endfunction

    // start-of-frame markers
    function automatic logic is_sof(input logic [7:0] m);
        return (m >= MARK_SOF0) && (m <= MARK_SOF15) &&
               (m != MARK_DHT) && (m != MARK_JPG) && (m != MARK_DAC);
    endfunction

endpackage

>>> hdl/ihsp_in_reg.sv
module ihsp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_out_free,
    output logic       o_take,
    output logic [7:0] o_byte,
    output logic       o_last
);
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // a byte moves on unless it is a last byte facing a full result register
    assign o_take     = r_valid && (!r_last || i_out_free);
    assign o_in_ready = !r_valid || o_take;
    assign n_valid    = (i_in_valid && o_in_ready) || (r_valid && !o_take);

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_last = r_last;
endmodule

>>> hdl/ihsp_parser.sv
module ihsp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output ihsp_pkg::t_result o_result
);
    import ihsp_pkg::*;

    t_parse_state r_st;
    t_parse_state n_st;
    t_parse_state upd;
    logic [15:0]  seg_len;
    logic [4:0]   off;
    logic [7:0]   b;

    assign off     = r_st.byte_offset;
    assign b       = i_byte;
    assign seg_len = {r_st.length_high, b};

    // one byte of header parsing
    always_comb begin
        upd = r_st;
        if (r_st.byte_offset != 5'd31) begin
            upd.byte_offset = r_st.byte_offset + 5'd1;
        end
        unique case (r_st.phase)
            PH_FIRST: begin
                if (b == BYTE_PNG0) begin
                    upd.phase = PH_PNG;
                end else if (b == BYTE_GIF_G) begin
                    upd.phase = PH_GIF;
                end else if (b == BYTE_FF) begin
                    upd.phase = PH_SOI;
                end else begin
                    upd.phase = PH_DONE;
                end
            end
            PH_PNG: begin
                if (off < 5'd8) begin
                    if (b != png_sig(off[2:0])) begin
                        upd.phase = PH_DONE;
                    end else if (off == 5'd7) begin
                        upd.format_seen = FMT_PNG;
                        upd.found_flag  = 1'b1;
                    end
                end else begin
                    unique case (off)
                        5'd16: upd.width_acc[31:24] = r_st.width_acc[31:24] | b;
                        5'd17: upd.width_acc[23:16] = r_st.width_acc[23:16] | b;
                        5'd18: upd.width_acc[15:8]  = r_st.width_acc[15:8] | b;
                        5'd19: upd.width_acc[7:0]   = r_st.width_acc[7:0] | b;
                        5'd20: upd.height_acc[31:24] = r_st.height_acc[31:24] | b;
                        5'd21: upd.height_acc[23:16] = r_st.height_acc[23:16] | b;
                        5'd22: upd.height_acc[15:8]  = r_st.height_acc[15:8] | b;
                        5'd23: begin
                            upd.height_acc[7:0] = r_st.height_acc[7:0] | b;
                            upd.phase           = PH_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            PH_GIF: begin
                unique case (off)
                    5'd1: begin
                        if (b != BYTE_GIF_I) upd.phase = PH_DONE;
                    end
                    5'd2: begin
                        if (b != BYTE_GIF_F) begin
                            upd.phase = PH_DONE;
                        end else begin
                            upd.format_seen = FMT_GIF;
                            upd.found_flag  = 1'b1;
                        end
                    end
                    5'd6: upd.width_acc[7:0]   = r_st.width_acc[7:0] | b;
                    5'd7: upd.width_acc[15:8]  = r_st.width_acc[15:8] | b;
                    5'd8: upd.height_acc[7:0]  = r_st.height_acc[7:0] | b;
                    5'd9: begin
                        upd.height_acc[15:8] = r_st.height_acc[15:8] | b;
                        upd.phase            = PH_DONE;
                    end
                    default: ;
                endcase
            end
            PH_SOI: begin
                if (b == MARK_SOI) begin
                    upd.format_seen = FMT_JPEG;
                    upd.phase       = PH_MARK0;
                end else begin
                    upd.phase = PH_DONE;
                end
            end
            PH_MARK0: begin
                upd.phase = (b == BYTE_FF) ? PH_MARK1 : PH_DONE;
            end
            PH_MARK1: begin
                if (is_standalone(b)) begin
                    upd.phase = PH_MARK0;
                end else begin
                    upd.current_marker = b;
                    if (is_sof(b)) begin
                        upd.found_flag = 1'b1;
                        upd.width_acc  = 32'd0;
                        upd.height_acc = 32'd0;
                    end
                    upd.phase = PH_LEN0;
                end
            end
            PH_LEN0: begin
                upd.length_high = b;
                upd.phase       = PH_LEN1;
            end
            PH_LEN1: begin
                if (is_sof(r_st.current_marker)) begin
                    upd.sof_index = 3'd0;
                    upd.phase     = PH_SOF;
                end else if (seg_len < 16'd2) begin
                    upd.phase = PH_DONE;
                end else begin
                    upd.skip_count = seg_len - 16'd2;
                    upd.phase      = (seg_len == 16'd2) ? PH_MARK0 : PH_SKIP;
                end
            end
            PH_SKIP: begin
                upd.skip_count = r_st.skip_count - 16'd1;
                if (r_st.skip_count == 16'd1) upd.phase = PH_MARK0;
            end
            PH_SOF: begin
                unique case (r_st.sof_index)
                    3'd1: upd.height_acc[15:8] = r_st.height_acc[15:8] | b;
                    3'd2: upd.height_acc[7:0]  = r_st.height_acc[7:0] | b;
                    3'd3: upd.width_acc[15:8]  = r_st.width_acc[15:8] | b;
                    3'd4: begin
                        upd.width_acc[7:0] = r_st.width_acc[7:0] | b;
                        upd.phase          = PH_DONE;
                    end
                    default: ;
                endcase
                upd.sof_index = r_st.sof_index + 3'd1;
            end
            PH_DONE: ;
            default: upd.phase = PH_DONE;
        endcase
    end

    // result fields straight from the updated state
    assign o_result.image_width  = upd.found_flag ? upd.width_acc : 32'd0;
    assign o_result.image_height = upd.found_flag ? upd.height_acc : 32'd0;
    assign o_result.image_format = upd.format_seen;
    assign o_result.dims_found   = upd.found_flag;

    // back to the start after the last byte of a file
    assign n_st = !i_take ? r_st : (i_last ? STATE_RESET : upd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= STATE_RESET;
        end else begin
            r_st <= n_st;
        end
    end
endmodule

>>> hdl/image_header_size_parser_unit.sv
// Image header size parser: feed a file one byte per request, from offset zero, with
// i_last_byte set on its final byte; one result with width, height, format (PNG, GIF,
// JPEG or unknown) and a found flag follows that byte. Bytes are taken at one per cycle
// while no last byte waits: each passes an input register and the parser logic, and the
// result waits in an output register, so throughput is one byte per clock, with the same
// exception. Only when a result is still held and not taken does the last byte of the
// next file wait; ordinary bytes keep flowing.
module image_header_size_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_image_width,
    output logic [31:0] o_image_height,
    output logic [1:0]  o_image_format,
    output logic        o_dims_found
);
    import ihsp_pkg::*;

    logic       take;
    logic       out_free;
    logic [7:0] s1_byte;
    logic       s1_last;
    t_result    res;
    t_result    r_res;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       load;

    assign out_free = !r_out_valid || i_out_ready;

    // input register stage
    ihsp_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_byte      (s1_byte),
        .o_last      (s1_last)
    );

    // parser state and next-state logic
    ihsp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (s1_byte),
        .i_last   (s1_last),
        .o_result (res)
    );

    // result register
    assign load        = take && s1_last;
    assign n_out_valid = load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_image_width  = r_res.image_width;
    assign o_image_height = r_res.image_height;
    assign o_image_format = r_res.image_format;
    assign o_dims_found   = r_res.dims_found;

`ifndef ASSERT_OFF
    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_out_valid |-> i_out_ready)
        else $error("result overwritten while held");

    // sizes are zero when nothing was found
    a_zero_when_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_dims_found |-> (o_image_width == 32'd0) && (o_image_height == 32'd0))
        else $error("nonzero size without dimensions");

    // found dimensions always come with a known format
    a_format_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dims_found |-> o_image_format != FMT_UNKNOWN)
        else $error("dimensions found with unknown format");
`endif
endmodule

>>> test/tb_top.sv
module tb_top;
    import ihsp_pkg::*;

    // one byte request with its end-of-file flag
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold;
    } t_request;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [1:0]  image_format;
    logic        dims_found;

    t_request   pending_q[$];
    t_result    expected_q[$];
    logic [7:0] file_buf[$];
    int         mismatches = 0;

    // header parser state
    logic [4:0]  hdr_offset;
    t_phase      parse_ph;
    logic [15:0] skip_left;
    logic [7:0]  seg_marker;
    logic [7:0]  seg_len_hi;
    logic [2:0]  frame_idx;
    logic [31:0] acc_width;
    logic [31:0] acc_height;
    logic [1:0]  seen_format;
    logic        dims_known;

    image_header_size_parser_unit DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_last_byte    (last_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_image_width  (image_width),
        .o_image_height (image_height),
        .o_image_format (image_format),
        .o_dims_found   (dims_found)
    );

    // clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // png signature byte at a header position
    function automatic logic [7:0] png_magic(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = BYTE_PNG0;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h4E;
            3'd3:    v = 8'h47;
            3'd4:    v = 8'h0D;
            3'd5:    v = 8'h0A;
            3'd6:    v = 8'h1A;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

    // append one byte to the file being built
    task automatic add_file_byte(input logic [7:0] v);
        file_buf.insert(file_buf.size(), v);
    endtask

    // jpeg markers with no length field
    function automatic bit no_length_marker(input logic [7:0] m);
        return m == MARK_SOI || m == MARK_TEM || (m >= MARK_RST0 && m <= MARK_RST7);
    endfunction

    // start-of-frame codes, minus dht, jpg and dac
    function automatic bit frame_marker(input logic [7:0] m);
        return m >= MARK_SOF0 && m <= MARK_SOF15 && m != MARK_DHT && m != MARK_JPG
            && m != MARK_DAC;
    endfunction

    // random byte biased toward the extremes
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // idle cycles before the next request, with calm stretches
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(15, 60);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic clear_parser();
        hdr_offset  = 5'd0;
        parse_ph    = PH_FIRST;
        skip_left   = 16'd0;
        seg_marker  = 8'd0;
        seg_len_hi  = 8'd0;
        frame_idx   = 3'd0;
        acc_width   = 32'd0;
        acc_height  = 32'd0;
        seen_format = FMT_UNKNOWN;
        dims_known  = 1'b0;
    endtask

    // advance the header parser by one byte; queue a result on the last byte
    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [15:0] seg_len;
        t_result     res;
        int          shift;
        case (parse_ph)
            PH_FIRST: begin
                if (b == BYTE_PNG0)
                    parse_ph = PH_PNG;
                else if (b == BYTE_GIF_G)
                    parse_ph = PH_GIF;
                else if (b == BYTE_FF)
                    parse_ph = PH_SOI;
                else
                    parse_ph = PH_DONE;
            end
            PH_PNG: begin
                if (hdr_offset < 5'd8) begin
                    if (b != png_magic(hdr_offset[2:0])) begin
                        parse_ph = PH_DONE;
                    end else if (hdr_offset == 5'd7) begin
                        seen_format = FMT_PNG;
                        dims_known  = 1'b1;
                    end
                end else if (hdr_offset >= 5'd16 && hdr_offset <= 5'd19) begin
                    shift = 8 * (19 - int'(hdr_offset));
                    acc_width |= {24'd0, b} << shift;
                end else if (hdr_offset >= 5'd20 && hdr_offset <= 5'd23) begin
                    shift = 8 * (23 - int'(hdr_offset));
                    acc_height |= {24'd0, b} << shift;
                    if (hdr_offset == 5'd23)
                        parse_ph = PH_DONE;
                end
            end
            PH_GIF: begin
                case (hdr_offset)
                    5'd1: if (b != BYTE_GIF_I) parse_ph = PH_DONE;
                    5'd2: begin
                        if (b != BYTE_GIF_F) begin
                            parse_ph = PH_DONE;
                        end else begin
                            seen_format = FMT_GIF;
                            dims_known  = 1'b1;
                        end
                    end
                    5'd6: acc_width |= {24'd0, b};
                    5'd7: acc_width |= {16'd0, b, 8'd0};
                    5'd8: acc_height |= {24'd0, b};
                    5'd9: begin
                        acc_height |= {16'd0, b, 8'd0};
                        parse_ph = PH_DONE;
                    end
                    default: ;
                endcase
            end
            PH_SOI: begin
                if (b == MARK_SOI) begin
                    seen_format = FMT_JPEG;
                    parse_ph    = PH_MARK0;
                end else begin
                    parse_ph = PH_DONE;
                end
            end
            PH_MARK0: parse_ph = (b == BYTE_FF) ? PH_MARK1 : PH_DONE;
            PH_MARK1: begin
                if (no_length_marker(b)) begin
                    parse_ph = PH_MARK0;
                end else begin
                    seg_marker = b;
                    if (frame_marker(b)) begin
                        dims_known = 1'b1;
                        acc_width  = 32'd0;
                        acc_height = 32'd0;
                    end
                    parse_ph = PH_LEN0;
                end
            end
            PH_LEN0: begin
                seg_len_hi = b;
                parse_ph   = PH_LEN1;
            end
            PH_LEN1: begin
                seg_len = {seg_len_hi, b};
                if (frame_marker(seg_marker)) begin
                    frame_idx = 3'd0;
                    parse_ph  = PH_SOF;
                end else if (seg_len < 16'd2) begin
                    parse_ph = PH_DONE;
                end else begin
                    skip_left = seg_len - 16'd2;
                    parse_ph  = (skip_left == 16'd0) ? PH_MARK0 : PH_SKIP;
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0)
                    parse_ph = PH_MARK0;
            end
            PH_SOF: begin
                case (frame_idx)
                    3'd1: acc_height |= {16'd0, b, 8'd0};
                    3'd2: acc_height |= {24'd0, b};
                    3'd3: acc_width |= {16'd0, b, 8'd0};
                    3'd4: begin
                        acc_width |= {24'd0, b};
                        parse_ph = PH_DONE;
                    end
                    default: ;
                endcase
                frame_idx = frame_idx + 3'd1;
            end
            default: parse_ph = PH_DONE;
        endcase
        if (hdr_offset != 5'd31)
            hdr_offset = hdr_offset + 5'd1;
        if (last) begin
            res.image_width  = dims_known ? acc_width : 32'd0;
            res.image_height = dims_known ? acc_height : 32'd0;
            res.image_format = seen_format;
            res.dims_found   = dims_known;
            expected_q.insert(expected_q.size(), res);
            clear_parser();
        end
    endtask

    // turn the file buffer into byte requests
    task automatic emit_file(input bit hold);
        t_request req;
        int       i;
        for (i = 0; i < file_buf.size(); i++) begin
            req.data = file_buf[i];
            req.last = (i == file_buf.size() - 1);
            req.hold = hold && (i == 0);
            pending_q.insert(pending_q.size(), req);
        end
        file_buf.delete();
    endtask

    // random png, gif, jpeg or noise file, sometimes broken or cut short
    task automatic build_random_file();
        int          kind;
        int          n;
        int          r;
        int          seg_len;
        logic [7:0]  code;
        bit          stop;
        kind = $urandom_range(0, 19);
        stop = 0;
        if (kind < 5) begin
            for (n = 0; n < 8; n++)
                add_file_byte(png_magic(n[2:0]));
            repeat (8) add_file_byte(8'($urandom_range(0, 255)));
            repeat (8) add_file_byte(pick_byte());
            repeat ($urandom_range(0, 12)) add_file_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(0, 7);
                file_buf[n] ^= 8'($urandom_range(1, 255));
            end
        end else if (kind < 9) begin
            add_file_byte(BYTE_GIF_G);
            add_file_byte(BYTE_GIF_I);
            add_file_byte(BYTE_GIF_F);
            repeat (3) add_file_byte(8'($urandom_range(0, 255)));
            repeat (4) add_file_byte(pick_byte());
            repeat ($urandom_range(0, 12)) add_file_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(0, 2);
                file_buf[n] ^= 8'($urandom_range(1, 255));
            end
        end else if (kind < 17) begin
            add_file_byte(BYTE_FF);
            if ($urandom_range(0, 15) == 0)
                add_file_byte(8'($urandom_range(0, 255)));
            else
                add_file_byte(MARK_SOI);
            // segments ahead of the frame header
            repeat ($urandom_range(0, 4)) begin
                if (!stop) begin
                    if ($urandom_range(0, 9) < 3) begin
                        r = $urandom_range(0, 9);
                        if (r == 0)
                            code = MARK_SOI;
                        else if (r == 1)
                            code = MARK_TEM;
                        else
                            code = MARK_RST0 + 8'(r - 2);
                        add_file_byte(BYTE_FF);
                        add_file_byte(code);
                    end else begin
                        do
                            code = 8'($urandom_range(0, 255));
                        while (no_length_marker(code) || frame_marker(code));
                        add_file_byte(BYTE_FF);
                        add_file_byte(code);
                        r = $urandom_range(0, 15);
                        if (r == 0)
                            seg_len = $urandom_range(0, 1);
                        else if (r == 1)
                            seg_len = $urandom_range(0, 65535);
                        else
                            seg_len = $urandom_range(2, 14);
                        add_file_byte(8'(seg_len >> 8));
                        add_file_byte(8'(seg_len));
                        if (seg_len < 2 || seg_len > 300) begin
                            repeat ($urandom_range(0, 20))
                                add_file_byte(8'($urandom_range(0, 255)));
                            stop = 1;
                        end else begin
                            repeat (seg_len - 2)
                                add_file_byte(8'($urandom_range(0, 255)));
                        end
                    end
                end
            end
            // a stray byte where a marker should start
            if (!stop && $urandom_range(0, 11) == 0) begin
                add_file_byte(8'($urandom_range(0, 254)));
                stop = 1;
            end
            if (!stop && $urandom_range(0, 3) != 0) begin
                do
                    code = 8'($urandom_range(0, 255));
                while (!frame_marker(code));
                add_file_byte(BYTE_FF);
                add_file_byte(code);
                repeat (3) add_file_byte(8'($urandom_range(0, 255)));
                repeat (4) add_file_byte(pick_byte());
                repeat ($urandom_range(0, 6)) add_file_byte(8'($urandom_range(0, 255)));
            end
            repeat ($urandom_range(0, 4)) add_file_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 12)) add_file_byte(8'($urandom_range(0, 255)));
        end
        // truncated file
        if ($urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, file_buf.size());
            while (file_buf.size() > n)
                void'(file_buf.pop_back());
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // byte request driver
    int       send_gap = 0;
    int       send_calm = 0;
    t_request next_req;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            data_byte <= 8'd0;
            last_byte <= 1'b0;
            send_gap  = 0;
            clear_parser();
        end else begin
            if (in_valid && in_ready)
                parse_byte(data_byte, last_byte);
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_q.size() != 0 &&
                             (!pending_q[0].hold || expected_q.size() == 0)) begin
                    next_req = pending_q.pop_front();
                    data_byte <= next_req.data;
                    last_byte <= next_req.last;
                    in_valid  <= 1'b1;
                    send_gap  = draw_wait(send_calm);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    int      take_stall = 0;
    int      take_calm = 0;
    t_result want;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: width %0h height %0h format %0d found %0b",
                                 image_width, image_height, image_format, dims_found);
                end else begin
                    want = expected_q.pop_front();
                    report_field("image_width", want.image_width, image_width);
                    report_field("image_height", want.image_height, image_height);
                    report_field("image_format", 32'(want.image_format), 32'(image_format));
                    report_field("dims_found", 32'(want.dims_found), 32'(dims_found));
                end
                take_stall = draw_wait(take_calm);
            end
            if (take_stall > 0) begin
                take_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        // one byte, unknown
        file_buf = '{8'h00};
        emit_file(0);
        // partial gif signature
        file_buf = '{BYTE_GIF_G, BYTE_GIF_I};
        emit_file(0);
        // gif with largest sizes, sent once the block has drained
        file_buf = '{BYTE_GIF_G, BYTE_GIF_I, BYTE_GIF_F, 8'h38, 8'h39, 8'h61,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF};
        emit_file(1);
        // standalone markers, then a frame header cut at its code
        file_buf = '{BYTE_FF, MARK_SOI, BYTE_FF, MARK_SOI, BYTE_FF, MARK_TEM,
                     BYTE_FF, MARK_RST7, BYTE_FF, MARK_RST0, BYTE_FF, MARK_SOF0};
        emit_file(0);
        // empty segment, skipped segment, full frame header
        file_buf = '{BYTE_FF, MARK_SOI, BYTE_FF, BYTE_FF, 8'h00, 8'h02,
                     BYTE_FF, 8'hDB, 8'h00, 8'h03, 8'h00,
                     BYTE_FF, MARK_SOF15, 8'h00, 8'h11, 8'h08, 8'h12, 8'h34, 8'h56, 8'h78};
        emit_file(0);
        // segment length below two
        file_buf = '{BYTE_FF, MARK_SOI, BYTE_FF, 8'hE0, 8'h00, 8'h01};
        emit_file(0);
        // no marker where one should start
        file_buf = '{BYTE_FF, MARK_SOI, 8'h7F};
        emit_file(0);
        // end of file inside a length
        file_buf = '{BYTE_FF, MARK_SOI, BYTE_FF, MARK_DHT, 8'h00};
        emit_file(0);
        // end of file inside a skip
        file_buf = '{BYTE_FF, MARK_SOI, BYTE_FF, 8'hD9, 8'h00, 8'h04, 8'h11};
        emit_file(0);
        // partial png signature
        file_buf = '{BYTE_PNG0, 8'h50, 8'h4E, 8'h47};
        emit_file(0);

        while (pending_q.size() < 1950) begin
            build_random_file();
            emit_file($urandom_range(0, 39) == 0);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // hang guard
    initial begin
        #6000000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> image_header_size_parser_unit.f
hdl/ihsp_pkg.sv
hdl/ihsp_in_reg.sv
hdl/ihsp_parser.sv
hdl/image_header_size_parser_unit.sv
test/tb_top.sv
